@@ design/rhsv_pkg.sv @@
`timescale 1ns / 1ps

package rhsv_pkg;

  // Number of quotient bits, one per divider cell
  localparam int unsigned QBITS = 8;

  localparam logic [12:0] HUE_SECTOR    = 13'd30;
  localparam logic [7:0]  HUE_WRAP      = 8'd180;
  localparam logic [7:0]  HUE_GREEN_OFS = 8'd60;
  localparam logic [7:0]  HUE_BLUE_OFS  = 8'd120;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // Everything one pipeline stage carries for an item
  typedef struct packed {
    logic [15:0] hrem;  // hue partial remainder
    logic [14:0] hdiv;  // hue divisor, aligned to the current quotient bit
    logic [7:0]  hq;    // hue quotient bits so far
    logic [15:0] srem;  // saturation partial remainder
    logic [14:0] sdiv;  // saturation divisor, aligned
    logic [7:0]  sq;    // saturation quotient bits so far
    logic [7:0]  mx;
    chan_t       chan;
    logic        neg;   // hue difference is negative
    logic        grey;  // spread is zero
  } word_t;

endpackage

@@ design/rhsv_front.sv @@
`timescale 1ns / 1ps

module rhsv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  output logic               ready_up,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               valid_out,
  input  logic               ready_dn,
  output rhsv_pkg::word_t    word_out
);

  logic            valid_r, valid_nxt;
  rhsv_pkg::word_t word_r, word_nxt;

  logic [7:0]        mx, mn, d, x, y, diff;
  rhsv_pkg::chan_t   chan;
  logic [12:0]       hnum;
  logic [15:0]       snum;

  always_comb begin
    if (red >= green && red >= blue) begin
      chan = rhsv_pkg::CH_RED;
      mx   = red;
      x    = green;
      y    = blue;
    end else if (green >= blue) begin
      chan = rhsv_pkg::CH_GREEN;
      mx   = green;
      x    = blue;
      y    = red;
    end else begin
      chan = rhsv_pkg::CH_BLUE;
      mx   = blue;
      x    = red;
      y    = green;
    end
  end

  always_comb begin
    mn = (red < green) ? red : green;
    if (blue < mn) begin
      mn = blue;
    end
  end

  assign d    = mx - mn;
  assign diff = (x >= y) ? (x - y) : (y - x);
  assign hnum = {5'd0, diff} * rhsv_pkg::HUE_SECTOR;
  // 255 * d as a shift and subtract
  assign snum = {d, 8'd0} - {8'd0, d};

  always_comb begin
    word_nxt.hrem = {3'd0, hnum};
    word_nxt.hdiv = {d, 7'd0};
    word_nxt.hq   = '0;
    word_nxt.srem = snum;
    word_nxt.sdiv = {mx, 7'd0};
    word_nxt.sq   = '0;
    word_nxt.mx   = mx;
    word_nxt.chan = chan;
    word_nxt.neg  = (x < y);
    word_nxt.grey = (d == 8'd0);
  end

  assign ready_up  = !valid_r || ready_dn;
  assign valid_nxt = ready_up ? valid_in : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;

endmodule

@@ design/rhsv_cell.sv @@
`timescale 1ns / 1ps

// One restoring-division step for both the hue and the saturation quotient
module rhsv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  output logic               ready_up,
  input  rhsv_pkg::word_t    word_in,
  output logic               valid_out,
  input  logic               ready_dn,
  output rhsv_pkg::word_t    word_out
);

  logic            valid_r, valid_nxt;
  rhsv_pkg::word_t word_r, word_nxt;
  logic            hge, sge;

  assign hge = word_in.hrem >= {1'b0, word_in.hdiv};
  assign sge = word_in.srem >= {1'b0, word_in.sdiv};

  always_comb begin
    word_nxt      = word_in;
    word_nxt.hrem = hge ? (word_in.hrem - {1'b0, word_in.hdiv}) : word_in.hrem;
    word_nxt.hdiv = word_in.hdiv >> 1;
    word_nxt.hq   = {word_in.hq[6:0], hge};
    word_nxt.srem = sge ? (word_in.srem - {1'b0, word_in.sdiv}) : word_in.srem;
    word_nxt.sdiv = word_in.sdiv >> 1;
    word_nxt.sq   = {word_in.sq[6:0], sge};
  end

  assign ready_up  = !valid_r || ready_dn;
  assign valid_nxt = ready_up ? valid_in : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;

endmodule

@@ design/rhsv_back.sv @@
`timescale 1ns / 1ps

module rhsv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  output logic               ready_up,
  input  rhsv_pkg::word_t    word_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_hue,
  output logic [7:0]         out_saturation,
  output logic [7:0]         out_value
);

  logic       valid_r, valid_nxt;
  logic [7:0] hue_r, hue_nxt;
  logic [7:0] sat_r, sat_nxt;
  logic [7:0] val_r, val_nxt;
  logic [7:0] base;
  logic       rem_nz;

  assign rem_nz = (word_in.hrem != 16'd0);

  always_comb begin
    case (word_in.chan)
      rhsv_pkg::CH_RED:   base = rhsv_pkg::HUE_WRAP;
      rhsv_pkg::CH_GREEN: base = rhsv_pkg::HUE_GREEN_OFS;
      rhsv_pkg::CH_BLUE:  base = rhsv_pkg::HUE_BLUE_OFS;
      default:            base = 8'd0;
    endcase
  end

  // Floor of a negative quotient steps one further down when the division is inexact
  always_comb begin
    if (word_in.grey) begin
      hue_nxt = 8'd0;
    end else if (word_in.neg) begin
      hue_nxt = base - word_in.hq - {7'd0, rem_nz};
    end else if (word_in.chan == rhsv_pkg::CH_RED) begin
      hue_nxt = word_in.hq;
    end else begin
      hue_nxt = base + word_in.hq;
    end
  end

  assign sat_nxt = (word_in.mx == 8'd0) ? 8'd0 : word_in.sq;
  assign val_nxt = word_in.mx;

  assign ready_up  = !valid_r || !out_stall;
  assign valid_nxt = ready_up ? valid_in : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_value      = val_r;

endmodule

@@ design/rgb_to_hsv_8bit_core.sv @@
`timescale 1ns / 1ps

// RGB to HSV converter, 8 bits per channel, hue in two-degree steps (0..179).
// Input channel: in_valid / in_stall with in_red, in_green, in_blue. An item
// is taken on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with out_hue, out_saturation,
// out_value, taken on a rising edge with out_valid high and out_stall low.
// The path is 10 register stages: one stage forms max, min, spread and
// numerators, a row of 8 division cells produces one quotient bit each for hue
// and saturation, and a final stage applies the hue offset and registers the
// result. out_valid rises once the item has passed the front stage, every
// division cell and the final stage. Throughput is one item per cycle while
// out_stall is low. Each stage has its own valid bit and takes a new item
// whenever it is empty or its successor moves on, so bubbles close up while
// the receiver stalls; in_stall rises only once every stage holds an item and
// out_stall is high. A held result stays stable until taken. Synchronous
// active-low reset empties every stage; payload registers are not reset.
module rgb_to_hsv_8bit_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_value
);

  logic            front_ready;
  logic            valid_chain [rhsv_pkg::QBITS+1];
  logic            ready_chain [rhsv_pkg::QBITS+1];
  rhsv_pkg::word_t word_chain  [rhsv_pkg::QBITS+1];

  rhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .ready_up  (front_ready),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .valid_out (valid_chain[0]),
    .ready_dn  (ready_chain[0]),
    .word_out  (word_chain[0])
  );

  assign in_stall = !front_ready;

  for (genvar i = 0; i < rhsv_pkg::QBITS; i++) begin : g_cell
    rhsv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (valid_chain[i]),
      .ready_up  (ready_chain[i]),
      .word_in   (word_chain[i]),
      .valid_out (valid_chain[i+1]),
      .ready_dn  (ready_chain[i+1]),
      .word_out  (word_chain[i+1])
    );
  end

  rhsv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_in       (valid_chain[rhsv_pkg::QBITS]),
    .ready_up       (ready_chain[rhsv_pkg::QBITS]),
    .word_in        (word_chain[rhsv_pkg::QBITS]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < rhsv_pkg::HUE_WRAP))
    else $error("hue out of range");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value == 8'd0) |-> (out_saturation == 8'd0))
    else $error("saturation non-zero on black item");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && valid_chain[0]))
    else $error("input stalled with room in the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !ready_chain[rhsv_pkg::QBITS])
    else $error("last stage ready while result held");
`endif

endmodule

@@ test/hsv_conversion_check.sv @@
`timescale 1ns / 1ps

module hsv_conversion_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_hue,
  input  logic [7:0] out_saturation,
  input  logic [7:0] out_value,
  output int         errors,
  output int         pending
);

  localparam int unsigned SECTOR    = 30;
  localparam int unsigned FULL_TURN = 180;
  localparam int unsigned GREEN_OFS = 60;
  localparam int unsigned BLUE_OFS  = 120;
  localparam int unsigned SAT_SCALE = 255;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  hsv_t hsv_queue[$];
  int   fail_count = 0;
  int   queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  function automatic hsv_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int unsigned top;
    int unsigned bottom;
    int unsigned spread;
    int unsigned num;
    hsv_t        res;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread  = top - bottom;
    res.val = top[7:0];
    res.hue = 8'd0;
    res.sat = 8'd0;
    if (spread != 0) begin
      // Red wins a tied maximum, then green
      if (top == r)
        num = FULL_TURN * spread + SECTOR * g - SECTOR * b;
      else if (top == g)
        num = GREEN_OFS * spread + SECTOR * b - SECTOR * r;
      else
        num = BLUE_OFS * spread + SECTOR * r - SECTOR * g;
      res.hue = 8'((num / spread) % FULL_TURN);
    end
    if (top != 0) res.sat = 8'((SAT_SCALE * spread) / top);
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hsv_queue.size() == 0) begin
          $display("%0t: unexpected result, got hue %0d sat %0d value %0d", $time,
                   out_hue, out_saturation, out_value);
          fail_count++;
        end else begin
          want = hsv_queue.pop_front();
          if (out_hue !== want.hue) begin
            $display("%0t: hue mismatch, expected %0d, got %0d", $time, want.hue, out_hue);
            fail_count++;
          end
          if (out_saturation !== want.sat) begin
            $display("%0t: saturation mismatch, expected %0d, got %0d", $time, want.sat,
                     out_saturation);
            fail_count++;
          end
          if (out_value !== want.val) begin
            $display("%0t: value mismatch, expected %0d, got %0d", $time, want.val,
                     out_value);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) hsv_queue.push_back(convert_pixel(in_red, in_green, in_blue));
    end
    queued <= hsv_queue.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 225;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_hue;
  logic [7:0] out_saturation;
  logic [7:0] out_value;

  logic in_taken = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet = 0;
  int   errors;
  int   pending;

  rgb_to_hsv_8bit_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_value     (out_value)
  );

  hsv_conversion_check check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_value     (out_value),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic push_random_pixel();
    int          kind;
    int          base;
    int          lo;
    int          pick;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  ends [4];
    ends = '{8'd0, 8'd1, 8'd254, 8'd255};
    kind = $urandom_range(9);
    r = 8'($urandom());
    g = 8'($urandom());
    b = 8'($urandom());
    case (kind)
      4: begin
        // near grey: tiny spread
        base = $urandom_range(252);
        r = 8'(base + $urandom_range(3));
        g = 8'(base + $urandom_range(3));
        b = 8'(base + $urandom_range(3));
      end
      5: begin
        // two channels share the maximum
        base = $urandom_range(1, 255);
        lo   = $urandom_range(base - 1);
        pick = $urandom_range(2);
        r = 8'(pick == 2 ? lo : base);
        g = 8'(pick == 1 ? lo : base);
        b = 8'(pick == 0 ? lo : base);
      end
      6: begin
        r = ends[$urandom_range(3)];
        g = ends[$urandom_range(3)];
        b = ends[$urandom_range(3)];
      end
      7: begin
        r = 8'($urandom_range(3));
        g = 8'($urandom_range(3));
        b = 8'($urandom_range(3));
      end
      8: begin
        pick = $urandom_range(2);
        if (pick == 0) r = 8'd255;
        else if (pick == 1) g = 8'd255;
        else b = 8'd255;
      end
      9: begin
        // spread of at most one
        base = $urandom_range(254);
        r = 8'(base + $urandom_range(1));
        g = 8'(base + $urandom_range(1));
        b = 8'(base + 1);
      end
      default: ;
    endcase
    push_pixel(r, g, b);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd1, 8'd1, 8'd1);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd1);
    push_pixel(8'd255, 8'd1, 8'd0);
    push_pixel(8'd1, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd1, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd1);
    push_pixel(8'd1, 8'd0, 8'd1);
    push_pixel(8'd255, 8'd254, 8'd254);
    push_pixel(8'd254, 8'd255, 8'd255);
    push_pixel(8'd170, 8'd85, 8'd0);
    push_pixel(8'd0, 8'd170, 8'd85);
    push_pixel(8'd85, 8'd0, 8'd170);
    push_pixel(8'd200, 8'd100, 8'd150);
    push_pixel(8'd2, 8'd1, 8'd0);
    push_pixel(8'd127, 8'd128, 8'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (PHASE_ITEMS) push_random_pixel();
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rhsv_pkg.sv
design/rhsv_front.sv
design/rhsv_cell.sv
design/rhsv_back.sv
design/rgb_to_hsv_8bit_core.sv
test/hsv_conversion_check.sv
test/testbench.sv
